FILE: hw/rtl/mca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the min-cost assignment core.
// Used by the channel interfaces, the solve engine, the result buffer and the top level.
package mca_pkg;

	localparam int COUNT_W = 5;
	localparam int INDEX_W = 4;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_ROW   = 2'd1,
		KIND_COL   = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [INDEX_W-1:0] row_index;
		logic [INDEX_W-1:0] col_index;
	} result_t;

	// candidate results from the engine; flush closes the matrix
	typedef struct packed {
		logic    cand_valid;
		result_t cand;
		logic    flush;
	} emit_ctl_t;

	typedef struct packed {
		logic pend_valid;
		logic out_valid;
	} buf_status_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_ROW_INIT,
		ST_HEAD_RD,
		ST_HEAD_OWN,
		ST_HEAD_POT,
		ST_SCAN,
		ST_UPDATE,
		ST_AUG,
		ST_EM_RD,
		ST_EM_ADDR,
		ST_EM_CHK,
		ST_EM_PUT,
		ST_EM_ROWS,
		ST_EM_COLS,
		ST_EM_END
	} state_t;

endpackage

FILE: hw/rtl/mca_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for cost items and result items.
// Depends on mca_pkg.
interface mca_in_if
	import mca_pkg::*;
#(
	parameter int COST_BITS = 16
) ();
	logic                 valid;
	logic                 ready;
	logic [COUNT_W-1:0]   row_count;
	logic [COUNT_W-1:0]   col_count;
	logic [COST_BITS-1:0] threshold;
	logic [COST_BITS-1:0] cost;
	logic                 last_cost;

	modport source (output valid, row_count, col_count, threshold, cost, last_cost,
		input ready);
	modport sink (input valid, row_count, col_count, threshold, cost, last_cost,
		output ready);
endinterface

interface mca_out_if
	import mca_pkg::*;
();
	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [INDEX_W-1:0] row_index;
	logic [INDEX_W-1:0] col_index;
	logic               last_result;

	modport source (output valid, kind, row_index, col_index, last_result, input ready);
	modport sink (input valid, kind, row_index, col_index, last_result, output ready);
endinterface

FILE: hw/rtl/mca_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/mca_engine.sv
`timescale 1ns / 1ps
// Load sequencer, Kuhn-Munkres solve sequencer and result walker.
// Depends on mca_pkg, mca_if and mca_ram (cost store, column records, row potentials).
module mca_engine
	import mca_pkg::*;
#(
	parameter int MAX_DIM   = 16,
	parameter int COST_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	mca_in_if.sink    items,
	output emit_ctl_t ctl,
	input  logic      stall
);
	localparam int SIDE  = MAX_DIM + 1;
	localparam int CW    = $clog2(SIDE);
	localparam int JW    = CW + 1;
	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = COST_BITS + IW + 8;
	localparam int CB1   = COST_BITS + 1;
	localparam logic signed [PW-1:0] FORBID    = PW'(64'd1 << (COST_BITS + 4));
	localparam logic signed [PW-1:0] SLACK_MAX = PW'(64'd1 << (PW - 2));

	typedef struct packed {
		logic signed [PW-1:0] pot;
		logic signed [PW-1:0] slack;
		logic [CW-1:0]        link;
		logic [CW-1:0]        owner;
		logic                 vis;
	} col_rec_t;

	localparam col_rec_t CLEAR_REC = '{pot: '0, slack: SLACK_MAX, link: '0, owner: '0,
		vis: 1'b0};

	state_t st_q, st_d;

	logic [AW:0]          fill_q;
	logic [CW-1:0]        rows_q, cols_q, n_q;
	logic [CW-1:0]        i_q, i0_q, j0_q, j1_q;
	logic [JW-1:0]        jc_q;
	logic signed [PW-1:0] u_q, delta_q;
	logic [AW-1:0]        base_q;
	logic                 v_s1, v_s2;
	logic [CW-1:0]        j_s1, own_s2;
	col_rec_t             hold_q;
	logic                 match_q;
	logic [MAX_DIM-1:0]   row_hit_q, col_hit_q;

	col_rec_t             col_rd, col_wd;
	logic                 col_we;
	logic [CW-1:0]        col_wa, col_ra;
	logic signed [PW-1:0] row_rd, row_wd;
	logic                 row_we;
	logic [CW-1:0]        row_wa, row_ra;
	logic [CB1-1:0]       cost_rd, cost_wd;
	logic                 cost_we;
	logic [AW-1:0]        cost_wa, cost_ra;

	logic [CW-1:0]        rows_in, cols_in;
	logic                 accept, in_empty, issue, adv;
	logic [2*CW-1:0]      own_prod;
	logic [AW-1:0]        em_addr;
	logic                 scan_forbid, scan_better;
	logic signed [PW-1:0] scan_w, scan_cur;
	col_rec_t             scan_rec, upd_rec, init_rec, aug_rec;

	mca_ram #(.WIDTH(CB1), .DEPTH(DEPTH)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
		.raddr(cost_ra), .rdata(cost_rd)
	);

	mca_ram #(.WIDTH($bits(col_rec_t)), .DEPTH(SIDE)) u_col_ram (
		.clk(clk), .we(col_we), .waddr(col_wa), .wdata(col_wd),
		.raddr(col_ra), .rdata(col_rd)
	);

	mca_ram #(.WIDTH(PW), .DEPTH(SIDE)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_wa), .wdata(row_wd),
		.raddr(row_ra), .rdata(row_rd)
	);

	assign rows_in  = (int'(items.row_count) > MAX_DIM) ? CW'(MAX_DIM) : CW'(items.row_count);
	assign cols_in  = (int'(items.col_count) > MAX_DIM) ? CW'(MAX_DIM) : CW'(items.col_count);
	assign in_empty = (rows_in == '0) || (cols_in == '0);
	assign accept   = items.valid && items.ready;
	assign issue    = (jc_q <= JW'(n_q));
	assign own_prod = (col_rd.owner - CW'(1)) * cols_q;
	assign em_addr  = AW'(own_prod) + AW'(jc_q - JW'(1));

	// scan stage: relax one column against the current row
	always_comb begin
		scan_forbid = (i0_q > rows_q) || (j_s1 > cols_q) || cost_rd[COST_BITS];
		scan_w = scan_forbid ? FORBID
			: $signed({{(PW-COST_BITS){1'b0}}, cost_rd[COST_BITS-1:0]});
		scan_cur = scan_w - u_q - col_rd.pot;
		scan_rec = col_rd;
		if (!col_rd.vis && (scan_cur < col_rd.slack)) begin
			scan_rec.slack = scan_cur;
			scan_rec.link  = j0_q;
		end
		scan_better = !col_rd.vis && (scan_rec.slack < delta_q);

		upd_rec = col_rd;
		if (col_rd.vis) begin
			upd_rec.pot = col_rd.pot - delta_q;
		end else begin
			upd_rec.slack = col_rd.slack - delta_q;
		end

		init_rec       = col_rd;
		init_rec.slack = SLACK_MAX;
		init_rec.vis   = 1'b0;
		if (j_s1 == '0) begin
			init_rec.owner = i_q;
		end

		aug_rec       = hold_q;
		aug_rec.owner = col_rd.owner;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d        = st_q;
		items.ready = 1'b0;
		col_ra      = jc_q[CW-1:0];
		col_we      = 1'b0;
		col_wa      = j_s1;
		col_wd      = col_rd;
		row_ra      = col_rd.owner;
		row_we      = 1'b0;
		row_wa      = own_s2;
		row_wd      = row_rd + delta_q;
		cost_ra     = base_q + AW'(jc_q - JW'(1));
		cost_we     = 1'b0;
		cost_wa     = fill_q[AW-1:0];
		cost_wd     = {(items.cost > items.threshold), items.cost};
		ctl         = '0;
		adv         = 1'b1;
		unique case (st_q)
			ST_LOAD: begin
				items.ready = 1'b1;
				if (items.valid) begin
					if (in_empty) begin
						if (items.last_cost) begin
							st_d = ST_EM_ROWS;
						end
					end else begin
						cost_we = (fill_q < (AW+1)'(DEPTH));
						if (items.last_cost) begin
							st_d = ST_CLEAR;
						end
					end
				end
			end
			ST_CLEAR: begin
				col_we = 1'b1;
				col_wa = jc_q[CW-1:0];
				col_wd = CLEAR_REC;
				row_we = 1'b1;
				row_wa = jc_q[CW-1:0];
				row_wd = '0;
				if (jc_q == JW'(n_q)) begin
					st_d = ST_ROW_INIT;
				end
			end
			ST_ROW_INIT: begin
				if (v_s1) begin
					col_we = 1'b1;
					col_wd = init_rec;
					if (j_s1 == n_q) begin
						st_d = ST_HEAD_RD;
					end
				end
			end
			ST_HEAD_RD: begin
				col_ra = j0_q;
				st_d   = ST_HEAD_OWN;
			end
			ST_HEAD_OWN: begin
				if (col_rd.owner == '0) begin
					col_ra = col_rd.link;
					st_d   = ST_AUG;
				end else begin
					col_we     = 1'b1;
					col_wa     = j0_q;
					col_wd     = col_rd;
					col_wd.vis = 1'b1;
					st_d       = ST_HEAD_POT;
				end
			end
			ST_HEAD_POT: begin
				st_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (v_s1) begin
					col_we = 1'b1;
					col_wd = scan_rec;
					if (j_s1 == n_q) begin
						st_d = ST_UPDATE;
					end
				end
			end
			ST_UPDATE: begin
				if (v_s1) begin
					col_we = 1'b1;
					col_wd = upd_rec;
				end
				row_we = v_s2;
				if (!issue && !v_s1 && !v_s2) begin
					st_d = ST_HEAD_RD;
				end
			end
			ST_AUG: begin
				// walk the alternating path back to the virtual column
				col_we = 1'b1;
				col_wa = j0_q;
				col_wd = aug_rec;
				col_ra = col_rd.link;
				if (hold_q.link == '0) begin
					st_d = (i_q == n_q) ? ST_EM_RD : ST_ROW_INIT;
				end
			end
			ST_EM_RD: begin
				st_d = ST_EM_ADDR;
			end
			ST_EM_ADDR: begin
				cost_ra = em_addr;
				st_d    = ST_EM_CHK;
			end
			ST_EM_CHK: begin
				st_d = ST_EM_PUT;
			end
			ST_EM_PUT: begin
				ctl.cand_valid = match_q;
				ctl.cand       = '{kind: KIND_MATCH, row_index: INDEX_W'(i0_q - CW'(1)),
					col_index: INDEX_W'(jc_q - JW'(1))};
				adv = !(match_q && stall);
				if (adv) begin
					st_d = (jc_q == JW'(n_q)) ? ST_EM_ROWS : ST_EM_RD;
				end
			end
			ST_EM_ROWS: begin
				if (jc_q < JW'(rows_q)) begin
					ctl.cand_valid = !row_hit_q[jc_q[IW-1:0]];
					ctl.cand = '{kind: KIND_ROW, row_index: INDEX_W'(jc_q), col_index: '0};
					adv = !(ctl.cand_valid && stall);
				end else begin
					st_d = ST_EM_COLS;
				end
			end
			ST_EM_COLS: begin
				if (jc_q < JW'(cols_q)) begin
					ctl.cand_valid = !col_hit_q[jc_q[IW-1:0]];
					ctl.cand = '{kind: KIND_COL, row_index: '0, col_index: INDEX_W'(jc_q)};
					adv = !(ctl.cand_valid && stall);
				end else begin
					st_d = ST_EM_END;
				end
			end
			ST_EM_END: begin
				ctl.flush = 1'b1;
				if (!stall) begin
					st_d = ST_LOAD;
				end
			end
			default: begin
				st_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			jc_q   <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (accept && in_empty && items.last_cost) begin
						fill_q    <= '0;
						jc_q      <= '0;
						rows_q    <= rows_in;
						cols_q    <= cols_in;
						row_hit_q <= '0;
						col_hit_q <= '0;
					end else if (accept && !in_empty) begin
						if (items.last_cost) begin
							fill_q <= '0;
							jc_q   <= '0;
							rows_q <= rows_in;
							cols_q <= cols_in;
							n_q    <= (rows_in > cols_in) ? rows_in : cols_in;
						end else if (cost_we) begin
							fill_q <= fill_q + (AW+1)'(1);
						end
					end
				end
				ST_CLEAR: begin
					if (jc_q == JW'(n_q)) begin
						jc_q <= '0;
						i_q  <= CW'(1);
						v_s1 <= 1'b0;
					end else begin
						jc_q <= jc_q + JW'(1);
					end
				end
				ST_ROW_INIT, ST_SCAN, ST_UPDATE: begin
					if (issue) begin
						jc_q <= jc_q + JW'(1);
					end
					v_s1 <= issue;
					j_s1 <= jc_q[CW-1:0];
					if (st_q == ST_ROW_INIT) begin
						j0_q <= '0;
					end
					if (st_q == ST_SCAN && v_s1 && scan_better) begin
						delta_q <= scan_rec.slack;
						j1_q    <= j_s1;
					end
					if (st_q == ST_UPDATE) begin
						v_s2   <= v_s1 && col_rd.vis;
						own_s2 <= col_rd.owner;
						if (!issue && !v_s1 && !v_s2) begin
							j0_q <= j1_q;
						end
					end
					if (st_q != ST_UPDATE && v_s1 && j_s1 == n_q) begin
						jc_q <= '0;
					end
				end
				ST_HEAD_OWN: begin
					i0_q   <= col_rd.owner;
					base_q <= AW'(own_prod);
					hold_q <= col_rd;
				end
				ST_HEAD_POT: begin
					u_q     <= row_rd;
					delta_q <= SLACK_MAX;
					j1_q    <= '0;
					jc_q    <= JW'(1);
					v_s1    <= 1'b0;
				end
				ST_AUG: begin
					j0_q   <= hold_q.link;
					hold_q <= col_rd;
					if (hold_q.link == '0) begin
						if (i_q == n_q) begin
							jc_q      <= JW'(1);
							row_hit_q <= '0;
							col_hit_q <= '0;
						end else begin
							i_q  <= i_q + CW'(1);
							jc_q <= '0;
						end
					end
				end
				ST_EM_ADDR: begin
					i0_q <= col_rd.owner;
				end
				ST_EM_CHK: begin
					match_q <= (i0_q != '0) && (i0_q <= rows_q) && (jc_q <= JW'(cols_q))
						&& !cost_rd[COST_BITS];
				end
				ST_EM_PUT: begin
					if (adv) begin
						if (match_q) begin
							row_hit_q[IW'(i0_q - CW'(1))] <= 1'b1;
							col_hit_q[IW'(jc_q - JW'(1))] <= 1'b1;
						end
						jc_q <= (jc_q == JW'(n_q)) ? '0 : jc_q + JW'(1);
					end
				end
				ST_EM_ROWS: begin
					if (jc_q >= JW'(rows_q)) begin
						jc_q <= '0;
					end else if (adv) begin
						jc_q <= jc_q + JW'(1);
					end
				end
				ST_EM_COLS: begin
					if (jc_q < JW'(cols_q) && adv) begin
						jc_q <= jc_q + JW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

FILE: hw/rtl/mca_result_buf.sv
`timescale 1ns / 1ps
// Result holding register and output register; marks the final beat of a matrix.
// Depends on mca_pkg and mca_if.
module mca_result_buf
	import mca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  emit_ctl_t   ctl,
	output logic        stall,
	output buf_status_t status,
	mca_out_if.source   results
);
	localparam result_t EMPTY_RES = '{kind: KIND_EMPTY, row_index: '0, col_index: '0};

	logic    pend_v_q, out_v_q, out_last_q;
	result_t pend_q, out_q, push_res;
	logic    out_free, push, push_last;

	assign out_free = !out_v_q || results.ready;

	// hold one result back so the final beat can carry last_result
	always_comb begin
		stall     = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		push_res  = pend_q;
		if (ctl.flush) begin
			stall     = !out_free;
			push      = out_free;
			push_last = 1'b1;
			push_res  = pend_v_q ? pend_q : EMPTY_RES;
		end else if (ctl.cand_valid && pend_v_q) begin
			stall = !out_free;
			push  = out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			if (ctl.flush && push) begin
				pend_v_q <= 1'b0;
			end else if (ctl.cand_valid && !stall) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= push_res;
			out_last_q <= push_last;
		end
		if (!ctl.flush && ctl.cand_valid && !stall) begin
			pend_q <= ctl.cand;
		end
	end

	assign results.valid       = out_v_q;
	assign results.kind        = out_q.kind;
	assign results.row_index   = out_q.row_index;
	assign results.col_index   = out_q.col_index;
	assign results.last_result = out_last_q;
	assign status.pend_valid   = pend_v_q;
	assign status.out_valid    = out_v_q;
endmodule

FILE: hw/rtl/min_cost_assignment_core.sv
`timescale 1ns / 1ps
// Min-cost assignment core (Kuhn-Munkres potentials). Loading takes one cost beat per cycle
// while in the load state. Solve per matrix of side n: a clear pass, then per row an init
// pass plus search steps through the column-record RAM, and a walk along the path.
// Report: a pass over the columns, then the unmatched rows and columns, plus output
// backpressure. Reset clears control only; the cost store is undefined.
module min_cost_assignment_core
	import mca_pkg::*;
#(
	parameter int MAX_DIM   = 16,
	parameter int COST_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	mca_in_if.sink    items,
	mca_out_if.source results
);
	emit_ctl_t   ctl;
	logic        stall;
	buf_status_t status;

	mca_engine #(.MAX_DIM(MAX_DIM), .COST_BITS(COST_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .items(items), .ctl(ctl), .stall(stall)
	);

	mca_result_buf u_result_buf (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stall(stall), .status(status),
		.results(results)
	);

	a_flush_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.flush && ctl.cand_valid))
		else $error("flush with a candidate result");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |-> !status.pend_valid)
		else $error("cost beat taken while a result is held");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.flush && !stall) |=> (!status.pend_valid && results.valid
		&& results.last_result))
		else $error("flush did not produce the final beat");
endmodule

FILE: tb/sv/min_cost_assignment_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for min_cost_assignment_core: cost matrices in, assignment report out.
// Depends on mca_pkg, the mca_in_if / mca_out_if channel interfaces and min_cost_assignment_core.
module min_cost_assignment_core_test;
	import mca_pkg::*;

	localparam int DIM       = 16;
	localparam int DEPTH     = DIM * DIM;
	localparam longint FORBID_WT = longint'(1) << 20;
	localparam longint SLACK_TOP = longint'(1) << 60;
	localparam int IDLE_LIMIT = 100000;

	typedef struct {
		kind_t      kind;
		logic [3:0] row_index;
		logic [3:0] col_index;
		logic       last_result;
	} report_t;

	logic clk;
	logic arst_n;

	mca_in_if #(.COST_BITS(16)) items_if ();
	mca_out_if results_if ();

	min_cost_assignment_core #(.MAX_DIM(DIM), .COST_BITS(16)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.results(results_if)
	);

	// predictor state
	logic [16:0] cost_mem [DEPTH];
	int          load_pos;
	report_t     expected_reports [$];

	int errors;
	int beats_sent;
	int reports_checked;
	int matrices_sent;
	int idle_cycles;
	bit gaps_on;
	bit ready_jitter;
	int hold_off;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = int'($urandom_range(0, 99));
		if (p < 60) return 0;
		if (p < 92) return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 40));
	endfunction

	function automatic longint weight_of(int i, int j, int rows, int cols);
		logic [16:0] w;
		if (i < 1 || j < 1 || i > rows || j > cols) return FORBID_WT;
		w = cost_mem[((i - 1) * cols + (j - 1)) % DEPTH];
		if (w[16]) return FORBID_WT;
		return longint'(w[15:0]);
	endfunction

	function automatic void add_report(kind_t k, int r, int c);
		report_t rep;
		rep.kind = k;
		rep.row_index = r[3:0];
		rep.col_index = c[3:0];
		rep.last_result = 1'b0;
		expected_reports = {expected_reports, rep};
	endfunction

	// Kuhn-Munkres with potentials; ties keep the lowest column
	function automatic void predict_assignment(input logic [4:0] rc, input logic [4:0] cc,
			input logic [15:0] thr, input logic [15:0] cost, input logic last);
		int rows, cols, n, i, j, j0, j1, i0;
		longint pot_r [17];
		longint pot_c [17];
		longint slack [17];
		longint delta, cur;
		int owner [17];
		int link [17];
		bit seen [17];
		bit row_hit [16];
		bit col_hit [16];
		rows = (rc > DIM) ? DIM : int'(rc);
		cols = (cc > DIM) ? DIM : int'(cc);
		if (rows == 0 || cols == 0) begin
			if (!last) return;
			load_pos = 0;
			for (i = 0; i < rows; i++) add_report(KIND_ROW, i, 0);
			for (j = 0; j < cols; j++) add_report(KIND_COL, 0, j);
			if (rows + cols == 0) add_report(KIND_EMPTY, 0, 0);
			expected_reports[$].last_result = 1'b1;
			return;
		end
		if (load_pos < DEPTH) begin
			cost_mem[load_pos] = {cost > thr, cost};
			load_pos++;
		end
		if (!last) return;
		load_pos = 0;
		n = rows > cols ? rows : cols;
		for (j = 0; j < 17; j++) begin
			pot_r[j] = 0;
			pot_c[j] = 0;
			owner[j] = 0;
			link[j] = 0;
		end
		for (i = 1; i <= n; i++) begin
			j0 = 0;
			owner[0] = i;
			for (j = 0; j < 17; j++) begin
				slack[j] = SLACK_TOP;
				seen[j] = 1'b0;
			end
			do begin
				i0 = owner[j0];
				j1 = 0;
				delta = SLACK_TOP;
				seen[j0] = 1'b1;
				for (j = 1; j <= n; j++) begin
					if (!seen[j]) begin
						cur = weight_of(i0, j, rows, cols) - pot_r[i0] - pot_c[j];
						if (cur < slack[j]) begin
							slack[j] = cur;
							link[j] = j0;
						end
						if (slack[j] < delta) begin
							delta = slack[j];
							j1 = j;
						end
					end
				end
				for (j = 0; j <= n; j++) begin
					if (seen[j]) begin
						pot_r[owner[j] % 17] += delta;
						pot_c[j] -= delta;
					end else begin
						slack[j] -= delta;
					end
				end
				j0 = j1;
			end while (owner[j0] != 0);
			do begin
				j1 = link[j0] % 17;
				owner[j0] = owner[j1];
				j0 = j1;
			end while (j0 != 0);
		end
		for (j = 0; j < 16; j++) begin
			row_hit[j] = 1'b0;
			col_hit[j] = 1'b0;
		end
		for (j = 1; j <= n; j++) begin
			i = owner[j];
			if (i >= 1 && i <= rows && j <= cols && weight_of(i, j, rows, cols) < FORBID_WT) begin
				add_report(KIND_MATCH, i - 1, j - 1);
				row_hit[i - 1] = 1'b1;
				col_hit[j - 1] = 1'b1;
			end
		end
		for (i = 0; i < rows; i++) if (!row_hit[i]) add_report(KIND_ROW, i, 0);
		for (j = 0; j < cols; j++) if (!col_hit[j]) add_report(KIND_COL, 0, j);
		expected_reports[$].last_result = 1'b1;
	endfunction

	task automatic send_beat(input logic [4:0] rc, input logic [4:0] cc,
			input logic [15:0] thr, input logic [15:0] cost, input logic last);
		int g;
		items_if.valid     <= 1'b1;
		items_if.row_count <= rc;
		items_if.col_count <= cc;
		items_if.threshold <= thr;
		items_if.cost      <= cost;
		items_if.last_cost <= last;
		do @(posedge clk); while (!items_if.ready);
		predict_assignment(rc, cc, thr, cost, last);
		beats_sent++;
		g = gaps_on ? gap_len() : 0;
		if (g > 0) begin
			items_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Send one matrix; costs beyond rows*cols are surplus entries.
	task automatic send_costs(input logic [4:0] rc, input logic [4:0] cc,
			input logic [15:0] thr, input int costs [$]);
		int k;
		for (k = 0; k < costs.size(); k++)
			send_beat(rc, cc, thr, costs[k][15:0], k == costs.size() - 1);
		matrices_sent++;
	endtask

	task automatic send_matrix(input logic [4:0] rc, input logic [4:0] cc,
			input logic [15:0] thr, input int mode, input int extra);
		int costs [$];
		int r, c, total, k;
		r = (rc > DIM) ? DIM : int'(rc);
		c = (cc > DIM) ? DIM : int'(cc);
		total = (r * c == 0) ? 1 : r * c + extra;
		for (k = 0; k < total; k++) begin
			case (mode)
				0: costs = {costs, int'($urandom_range(0, 65535))};
				1: costs = {costs, int'($urandom_range(0, 7))};
				default: costs = {costs, int'(thr) + int'($urandom_range(0, 8)) - 4};
			endcase
		end
		send_costs(rc, cc, thr, costs);
	endtask

	task automatic wait_drained();
		items_if.valid <= 1'b0;
		wait (expected_reports.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		gaps_on = 1'b0;
		send_costs(5'd2, 5'd2, 16'd100, '{5, 5, 5, 5});
		send_costs(5'd2, 5'd2, 16'hFFFF, '{0, 65535, 65535, 0});
		send_costs(5'd2, 5'd2, 16'd0, '{0, 1, 1, 0});
		send_costs(5'd1, 5'd3, 16'd10, '{7, 3, 3});
		send_costs(5'd3, 5'd1, 16'd32768, '{32768, 9, 9});
		// idle beat on an empty shape, then the empty marker
		send_beat(5'd0, 5'd0, 16'd0, 16'hFFFF, 1'b0);
		send_costs(5'd0, 5'd0, 16'd0, '{65535});
		send_costs(5'd0, 5'd3, 16'd5, '{1});
		send_costs(5'd31, 5'd0, 16'd5, '{1});
		gaps_on = 1'b1;
	endtask

	task automatic test_oversized();
		send_matrix(5'd31, 5'd1, 16'hFFFF, 0, 3);
		send_matrix(5'd1, 5'd17, 16'h8000, 0, 0);
	endtask

	task automatic test_surplus();
		send_matrix(5'd4, 5'd4, 16'($urandom_range(0, 65535)), 1, 6);
	endtask

	task automatic test_random();
		int stop_at, shape;
		logic [4:0] rc, cc;
		stop_at = beats_sent + 20;
		while (beats_sent < stop_at) begin
			shape = int'($urandom_range(0, 19));
			rc = 5'($urandom_range(1, 4));
			cc = 5'($urandom_range(1, 4));
			if (shape == 0) rc = 5'd0;
			if (shape == 1) cc = 5'd0;
			if (shape == 2) rc = 5'($urandom_range(5, 8));
			gaps_on = (shape != 3);
			send_matrix(rc, cc, 16'($urandom_range(0, 65535)), int'($urandom_range(0, 2)),
				(shape == 4) ? int'($urandom_range(1, 3)) : 0);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_off = 800;
		repeat (4) send_matrix(5'd2, 5'd2, 16'd40000, 0, 0);
		// pause input until every report is out
		wait_drained();
		send_matrix(5'd2, 5'd3, 16'd4, 1, 0);
		gaps_on = 1'b1;
	endtask

	// result side readiness
	initial begin
		int off;
		off = 0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				results_if.ready <= 1'b0;
				hold_off--;
			end else if (off > 0) begin
				results_if.ready <= 1'b0;
				off--;
			end else begin
				results_if.ready <= 1'b1;
				if (ready_jitter && $urandom_range(0, 3) == 0) off = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		report_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report kind=%0d row=%0d col=%0d", results_if.kind,
					results_if.row_index, results_if.col_index);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				reports_checked++;
				if (results_if.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, results_if.kind);
					errors++;
				end
				if (results_if.row_index !== want.row_index) begin
					$error("row_index: expected %0d, got %0d", want.row_index,
						results_if.row_index);
					errors++;
				end
				if (results_if.col_index !== want.col_index) begin
					$error("col_index: expected %0d, got %0d", want.col_index,
						results_if.col_index);
					errors++;
				end
				if (results_if.last_result !== want.last_result) begin
					$error("last_result: expected %0d, got %0d", want.last_result,
						results_if.last_result);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0;
		beats_sent = 0;
		reports_checked = 0;
		matrices_sent = 0;
		idle_cycles = 0;
		load_pos = 0;
		hold_off = 0;
		gaps_on = 1'b1;
		ready_jitter = 1'b0;
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.row_count = '0;
		items_if.col_count = '0;
		items_if.threshold = '0;
		items_if.cost = '0;
		items_if.last_cost = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		ready_jitter = 1'b1;
		test_oversized();
		test_random();
		test_surplus();
		test_backpressure();
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Covered %0d matrices in %0d cost beats; %0d reports checked.",
			matrices_sent, beats_sent, reports_checked);
		$display("Included empty, oversized, surplus, tied and fully stalled cases.");
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/mca_pkg.sv
hw/rtl/mca_if.sv
hw/rtl/mca_ram.sv
hw/rtl/mca_engine.sv
hw/rtl/mca_result_buf.sv
hw/rtl/min_cost_assignment_core.sv
tb/sv/min_cost_assignment_core_test.sv
